@@ hdl/wrpf_pkg.sv @@
// Shared types, constants and helper functions for the wildcard rule packet filter.
// Holds the microcode table, the command dispatch map and the pattern match function.
// No dependencies.
package wrpf_pkg;

	// Default sizing, overridable on the top level
	localparam int unsigned MAX_RULES_DEF   = 1024;
	localparam int unsigned ADDR_DIGITS_DEF = 8;

	// Field widths
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned TOTAL_W = 16;
	localparam int unsigned RULE_W  = 2 * ADDR_W + 1;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned DIGITS_MAX = ADDR_W / DIGIT_W;
	localparam logic [DIGIT_W-1:0] WILDCARD = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// Stream widths: input tdata {dst, src, permit}, output tdata result fields
	localparam int unsigned IN_TDATA_W  = 72;
	localparam int unsigned OUT_TDATA_W = 24;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_FILTER = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_e;

	// Microprogram steps
	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_DISPATCH = 3'd1,
		ST_LOAD     = 3'd2,
		ST_CLEAR    = 3'd3,
		ST_SCAN     = 3'd4,
		ST_TALLY    = 3'd5,
		ST_EMIT     = 3'd6
	} step_e;

	// Datapath operations
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_FETCH = 3'd1,
		OP_LOAD  = 3'd2,
		OP_CLEAR = 3'd3,
		OP_SCAN  = 3'd4,
		OP_TALLY = 3'd5,
		OP_EMIT  = 3'd6
	} op_e;

	typedef enum logic [1:0] {
		COND_TRUE     = 2'd0,
		COND_IN_VALID = 2'd1,
		COND_SCAN_END = 2'd2,
		COND_OUT_FREE = 2'd3
	} cond_e;

	// Next-step selection: jump to target when the condition holds, else stay, or dispatch on the command
	typedef enum logic {
		NX_COND     = 1'b0,
		NX_DISPATCH = 1'b1
	} nx_e;

	typedef struct packed {
		logic  in_rdy;
		op_e   op;
		cond_e cond;
		nx_e   nx;
		step_e target;
	} uword_t;

	// Control from sequencer to datapath
	typedef struct packed {
		op_e  op;
		logic go;
	} ctrl_t;

	// Status from datapath and ports to sequencer
	typedef struct packed {
		cmd_e cmd;
		logic in_valid;
		logic scan_end;
		logic out_free;
	} stat_t;

	// One result beat
	typedef struct packed {
		logic               table_full;
		logic [TOTAL_W-1:0] pass_total;
		logic               matched_any;
		logic               passed;
	} res_t;

	// Microcode ROM: one control word per step
	function automatic uword_t ucode_rom(input step_e step);
		uword_t w;
		w = '{in_rdy: 1'b0, op: OP_NONE, cond: COND_TRUE, nx: NX_COND, target: ST_IDLE};
		unique case (step)
			ST_IDLE: begin
				w = '{in_rdy: 1'b1, op: OP_FETCH, cond: COND_IN_VALID, nx: NX_COND,
					target: ST_DISPATCH};
			end
			ST_DISPATCH: begin
				w = '{in_rdy: 1'b0, op: OP_NONE, cond: COND_TRUE, nx: NX_DISPATCH,
					target: ST_IDLE};
			end
			ST_LOAD: begin
				w = '{in_rdy: 1'b0, op: OP_LOAD, cond: COND_TRUE, nx: NX_COND,
					target: ST_EMIT};
			end
			ST_CLEAR: begin
				w = '{in_rdy: 1'b0, op: OP_CLEAR, cond: COND_TRUE, nx: NX_COND,
					target: ST_EMIT};
			end
			ST_SCAN: begin
				w = '{in_rdy: 1'b0, op: OP_SCAN, cond: COND_SCAN_END, nx: NX_COND,
					target: ST_TALLY};
			end
			ST_TALLY: begin
				w = '{in_rdy: 1'b0, op: OP_TALLY, cond: COND_TRUE, nx: NX_COND,
					target: ST_EMIT};
			end
			ST_EMIT: begin
				w = '{in_rdy: 1'b0, op: OP_EMIT, cond: COND_OUT_FREE, nx: NX_COND,
					target: ST_IDLE};
			end
			default: begin
				w = '{in_rdy: 1'b0, op: OP_NONE, cond: COND_TRUE, nx: NX_COND,
					target: ST_IDLE};
			end
		endcase
		return w;
	endfunction

	// Dispatch map: command to first step of its routine
	function automatic step_e dispatch_map(input cmd_e cmd);
		step_e s;
		s = ST_IDLE;
		unique case (cmd)
			CMD_LOAD:   s = ST_LOAD;
			CMD_FILTER: s = ST_SCAN;
			CMD_CLEAR:  s = ST_CLEAR;
			CMD_NONE:   s = ST_IDLE;
		endcase
		return s;
	endfunction

	// Digit-wise wildcard match over the low 'digits' nibbles
	function automatic logic pattern_hits(input logic [ADDR_W-1:0] pat,
			input logic [ADDR_W-1:0] addr, input int unsigned digits);
		logic hit;
		logic [DIGIT_W-1:0] p;
		logic [DIGIT_W-1:0] a;
		hit = 1'b1;
		for (int unsigned d = 0; d < DIGITS_MAX; d++) begin
			p = pat[d*DIGIT_W +: DIGIT_W];
			a = addr[d*DIGIT_W +: DIGIT_W];
			if (d < digits && p != WILDCARD && p != a) begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

endpackage

@@ hdl/wrpf_rule_mem.sv @@
// Rule table storage: one write port and one registered read port.
// Each entry packs {permit, dst pattern, src pattern}; uses wrpf_pkg for widths.
module wrpf_rule_mem
	import wrpf_pkg::*;
#(
	parameter int unsigned DEPTH = MAX_RULES_DEF,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [RULE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [RULE_W-1:0] rd_data
);

	logic [RULE_W-1:0] mem [DEPTH];

	// Write a rule into the addressed entry; the datapath addresses the next free entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read one rule, data registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hdl/wrpf_useq.sv @@
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Uses wrpf_pkg for the ROM, dispatch map and control/status types.
module wrpf_useq
	import wrpf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctl,
	output logic  in_rdy
);

	step_e  step_q;
	step_e  step_d;
	uword_t uw;
	logic   cond_ok;

	// Fetch the control word and evaluate its condition
	always_comb begin
		uw = ucode_rom(step_q);
		unique case (uw.cond)
			COND_TRUE:     cond_ok = 1'b1;
			COND_IN_VALID: cond_ok = stat.in_valid;
			COND_SCAN_END: cond_ok = stat.scan_end;
			COND_OUT_FREE: cond_ok = stat.out_free;
		endcase
		if (uw.nx == NX_DISPATCH) begin
			step_d = dispatch_map(stat.cmd);
		end else if (cond_ok) begin
			step_d = uw.target;
		end else begin
			step_d = step_q;
		end
		ctl.op = uw.op;
		ctl.go = cond_ok;
		in_rdy = uw.in_rdy;
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

@@ hdl/wrpf_dpath.sv @@
// Filter datapath: captured item, rule count, pass counter, scan index and match logic.
// Instantiates wrpf_rule_mem; uses wrpf_pkg for types and the match function.
module wrpf_dpath
	import wrpf_pkg::*;
#(
	parameter int unsigned MAX_RULES   = MAX_RULES_DEF,
	parameter int unsigned ADDR_DIGITS = ADDR_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctl,
	input  cmd_e              cmd,
	input  logic              rule_permit,
	input  logic [ADDR_W-1:0] src_field,
	input  logic [ADDR_W-1:0] dst_field,
	output cmd_e              cmd_cur,
	output logic              scan_end,
	output res_t              res
);

	localparam int unsigned IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RULES);

	// Captured item
	cmd_e              cmd_q;
	logic              permit_q;
	logic [ADDR_W-1:0] src_q;
	logic [ADDR_W-1:0] dst_q;

	// Table and scan state
	logic [CNT_W-1:0]   count_q;
	logic [TOTAL_W-1:0] pass_q;
	logic [CNT_W-1:0]   idx_q;
	logic               rvld_q;
	logic               hit_q;
	logic               passed_q;

	logic              full;
	logic              wr_en;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [RULE_W-1:0] rd_data;
	logic              rd_permit;
	logic [ADDR_W-1:0] rd_src;
	logic [ADDR_W-1:0] rd_dst;
	logic              match;

	wrpf_rule_mem #(
		.DEPTH(MAX_RULES)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[IDX_W-1:0]),
		.wr_data({permit_q, dst_q, src_q}),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Decode control, match the rule read in the previous cycle
	always_comb begin
		full = (count_q == CNT_FULL);
		wr_en = (ctl.op == OP_LOAD) && !full;
		rd_en = (ctl.op == OP_SCAN) && (idx_q != '0);
		rd_addr = IDX_W'(idx_q - CNT_W'(1));
		{rd_permit, rd_dst, rd_src} = rd_data;
		match = rvld_q && pattern_hits(rd_src, src_q, ADDR_DIGITS)
			&& pattern_hits(rd_dst, dst_q, ADDR_DIGITS);
		scan_end = match || (idx_q == '0 && !rvld_q);
		cmd_cur = cmd_q;
		res.passed = passed_q;
		res.matched_any = hit_q;
		res.pass_total = pass_q;
		res.table_full = full;
	end

	// Hold the captured item
	always_ff @(posedge clk) begin
		if (ctl.op == OP_FETCH && ctl.go) begin
			cmd_q <= cmd;
			permit_q <= rule_permit;
			src_q <= src_field;
			dst_q <= dst_field;
		end
	end

	// Execute the current micro-operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pass_q <= '0;
			idx_q <= '0;
			rvld_q <= 1'b0;
			hit_q <= 1'b0;
			passed_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				OP_FETCH: begin
					if (ctl.go) begin
						idx_q <= count_q;
						rvld_q <= 1'b0;
						hit_q <= 1'b0;
						passed_q <= 1'b0;
					end
				end
				OP_LOAD: begin
					if (wr_en) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				OP_CLEAR: begin
					count_q <= '0;
					pass_q <= '0;
				end
				OP_SCAN: begin
					rvld_q <= rd_en;
					if (rd_en) begin
						idx_q <= idx_q - CNT_W'(1);
					end
					if (match) begin
						hit_q <= 1'b1;
						passed_q <= rd_permit;
					end
				end
				OP_TALLY: begin
					if (passed_q && pass_q != TOTAL_MAX) begin
						pass_q <= pass_q + TOTAL_W'(1);
					end
				end
				OP_NONE, OP_EMIT: begin
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ hdl/wildcard_rule_packet_filter_unit.sv @@
// Top level of the wildcard rule packet filter: stream ports and result output register.
// Instantiates wrpf_useq and wrpf_dpath; uses wrpf_pkg.
//
// Ordered-rule packet filter. Load beats append a permit or deny rule whose source and
// destination patterns are nibble strings with 0xF as a wildcard; filter beats are decided
// by the most recently loaded matching rule (no match means deny); clear beats empty the
// table and the pass counter. Every load, filter and clear beat yields one result beat;
// command 3 is swallowed. A small microprogram steps a single datapath, taking one beat at
// a time. From acceptance to result in the output register, load and clear pass through
// the dispatch step and their own step, and a filter passes through dispatch, scan and
// tally; the scan reads one rule per cycle, newest first, through the rule memory's single
// read port and stops at the first match. Command 3 gives no result and returns to idle.
// The input is ready again once the result enters the output register, and a result beat
// still waiting downstream holds the emit step and with it the input.
// The rule memory needs no clearing after reset.
module wildcard_rule_packet_filter_unit
	import wrpf_pkg::*;
#(
	parameter int unsigned MAX_RULES   = MAX_RULES_DEF,
	parameter int unsigned ADDR_DIGITS = ADDR_DIGITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// rule_permit [0], src_field [32:1], dst_field [64:33], zero fill [71:65]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// cmd [1:0]
	input  logic [CMD_W-1:0]       s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// passed [0], matched_any [1], pass_total [17:2], table_full [18], zero fill [23:19]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int unsigned RES_W = $bits(res_t);

	ctrl_t ctl;
	stat_t stat;
	cmd_e  cmd_cur;
	logic  scan_end;
	res_t  res;
	res_t  out_q;
	logic  out_vld_q;
	logic  out_free;

	assign out_free = !out_vld_q || m_axis_tready;

	// Gather status for the sequencer
	always_comb begin
		stat.cmd = cmd_cur;
		stat.in_valid = s_axis_tvalid;
		stat.scan_end = scan_end;
		stat.out_free = out_free;
	end

	wrpf_useq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.ctl   (ctl),
		.in_rdy(s_axis_tready)
	);

	wrpf_dpath #(
		.MAX_RULES  (MAX_RULES),
		.ADDR_DIGITS(ADDR_DIGITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cmd        (cmd_e'(s_axis_tuser)),
		.rule_permit(s_axis_tdata[0]),
		.src_field  (s_axis_tdata[ADDR_W:1]),
		.dst_field  (s_axis_tdata[2*ADDR_W:ADDR_W+1]),
		.cmd_cur    (cmd_cur),
		.scan_end   (scan_end),
		.res        (res)
	);

	// Output beat valid: set on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.op == OP_EMIT && ctl.go) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (ctl.op == OP_EMIT && ctl.go) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {(OUT_TDATA_W - RES_W)'(0), out_q};

endmodule
